### rtl/core/dll_pkg.sv
// Package for the bounded doubly linked list block.
// Holds the sizes, the command and status codes, and the transfer and cell control types.
// No dependencies.
package dll_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int POS_W   = 4;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] data_out;
        logic [POS_W-1:0]        position;
        logic                    last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_ROTATE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t              mode;
        logic signed [VAL_W-1:0] wr_value;
    } cell_ctrl_t;

endpackage

### rtl/core/dll_if.sv
// Valid/ready channel interfaces for the command and response sides.
// Depends on dll_pkg for the item types.
interface dll_cmd_if
    import dll_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface dll_rsp_if
    import dll_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### rtl/core/dll_cell.sv
// One cell of the list chain: holds the value at one position from the head.
// Depends on dll_pkg for the cell control type.
module dll_cell
    import dll_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic                    sel,
    input  logic signed [VAL_W-1:0] left,
    input  logic signed [VAL_W-1:0] right,
    output logic signed [VAL_W-1:0] q
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        case (ctrl.mode)
            CELL_SHIFT:  value_next = left;
            CELL_LOAD:   value_next = sel ? ctrl.wr_value : value_reg;
            CELL_ROTATE: value_next = sel ? ctrl.wr_value : right;
            default:     value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q = value_reg;

endmodule

### rtl/core/bounded_doubly_linked_list.sv
// Top level of the bounded doubly linked list: control sequencer, output register and cell chain.
// Depends on dll_pkg, dll_if and dll_cell.
//
//  Channel  Dir  Payload                                Transfer when
//  cmd      in   operation, value                       cmd.valid && cmd.ready
//  rsp      out  status, data_out, position, last       rsp.valid && rsp.ready
//
// Inserts finish in the execute state. Find, remove and dump then walk every entry held, as
// the chain rotates one position a cycle past the head cell unless a stalled response holds the walk.
// A command is taken whenever the sequencer is idle, even while a response still waits.
// Reset empties the list at once; no clearing pass is needed.
// A stalled response holds the walk at the step that would emit the next one.
module bounded_doubly_linked_list
    import dll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dll_cmd_if.sink   cmd,
    dll_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WALK = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [IDX_W-1:0]        last_reg, last_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic                    found_reg, found_next;
    logic [OP_W-1:0]         op_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    out_valid_reg;
    rsp_item_t               out_item_reg;

    cell_ctrl_t              ctrl;
    logic                    sel_en;
    logic [IDX_W-1:0]        sel_idx;
    logic [DEPTH-1:0]        sel;
    logic signed [VAL_W-1:0] cell_q [DEPTH];

    logic                    out_free;
    logic                    emit;
    rsp_item_t               emit_item;
    logic                    match;
    logic                    is_last;
    logic                    go;
    logic                    found_now;
    logic [IDX_W-1:0]        pos_now;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    assign match     = !found_reg && (cell_q[0] == val_reg);
    assign is_last   = (step_reg == last_reg);
    assign found_now = found_reg || match;
    assign pos_now   = match ? step_reg : pos_reg;

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        step_next          = step_reg;
        last_next          = last_reg;
        pos_next           = pos_reg;
        found_next         = found_reg;
        ctrl.mode          = CELL_HOLD;
        ctrl.wr_value      = val_reg;
        sel_en             = 1'b0;
        sel_idx            = count_reg[IDX_W-1:0];
        emit               = 1'b0;
        emit_item.status   = ST_OK;
        emit_item.data_out = val_reg;
        emit_item.position = '0;
        emit_item.last     = 1'b1;
        go                 = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    unique case (op_reg) inside
                        OP_INS_HEAD, OP_INS_TAIL:
                        begin
                            emit = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                emit_item.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                if (op_reg == OP_INS_HEAD)
                                begin
                                    ctrl.mode = CELL_SHIFT;
                                end
                                else
                                begin
                                    ctrl.mode = CELL_LOAD;
                                    sel_en    = 1'b1;
                                end
                            end
                        end
                        OP_FIND, OP_REMOVE, OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                                if (op_reg == OP_FIND)
                                begin
                                    emit_item.status = ST_NOT_FOUND;
                                end
                                else
                                begin
                                    emit_item.status = ST_EMPTY;
                                end
                                if (op_reg == OP_DUMP)
                                begin
                                    emit_item.data_out = '0;
                                end
                            end
                            else
                            begin
                                state_next = S_WALK;
                                step_next  = '0;
                                pos_next   = '0;
                                found_next = 1'b0;
                                last_next  = IDX_W'(count_reg - CNT_W'(1));
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                go = ((op_reg == OP_DUMP) || is_last) ? out_free : 1'b1;
                if (go)
                begin
                    ctrl.mode     = CELL_ROTATE;
                    ctrl.wr_value = cell_q[0];
                    sel_idx       = IDX_W'(count_reg - CNT_W'(1));
                    sel_en        = !((op_reg == OP_REMOVE) && match);
                    if ((op_reg == OP_REMOVE) && match)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    found_next = found_now;
                    pos_next   = pos_now;
                    step_next  = step_reg + IDX_W'(1);
                    if (op_reg == OP_DUMP)
                    begin
                        emit               = 1'b1;
                        emit_item.data_out = cell_q[0];
                        emit_item.position = POS_W'(step_reg);
                        emit_item.last     = is_last;
                    end
                    else if (is_last)
                    begin
                        emit = 1'b1;
                        if (found_now)
                        begin
                            emit_item.position = POS_W'(pos_now);
                        end
                        else
                        begin
                            emit_item.status = ST_NOT_FOUND;
                        end
                    end
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            last_reg      <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg  <= cmd.item.operation;
            val_reg <= cmd.item.value;
        end
        if (emit)
        begin
            out_item_reg <= emit_item;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign sel[i] = sel_en && (sel_idx == IDX_W'(i));

        if (i == 0)
        begin : g_head
            dll_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .sel   (sel[i]),
                .left  (ctrl.wr_value),
                .right (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
        else if (i == DEPTH - 1)
        begin : g_tail
            dll_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .sel   (sel[i]),
                .left  (cell_q[i-1]),
                .right (cell_q[i]),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_mid
            dll_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .sel   (sel[i]),
                .left  (cell_q[i-1]),
                .right (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
    end

endmodule

### rtl/core/dll_checker.sv
// Port-level checks for the bounded doubly linked list, bound to its top level.
// Depends on dll_pkg for the status codes and item types.
module dll_checker
    import dll_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp_item
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("Response changed or dropped while stalled.");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("Command taken on two consecutive cycles.");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status != ST_OK) |-> rsp_item.last && (rsp_item.position == '0))
        else $error("Error response is not a single result at position zero.");

    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.last |-> !cmd_ready)
        else $error("Command taken while a dump is still in progress.");

endmodule

bind bounded_doubly_linked_list dll_checker u_dll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.item)
);
